FILE: src/cqe_pkg.sv
`default_nettype none

package cqe_pkg;

    // Width of the capacity register port
    localparam int CAP_WIDTH = 11;

    // Capacity after reset, before limiting to the memory depth
    localparam int CAP_RESET = 1024;

    // Operation codes carried in the cmd field
    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/cqe_if.sv
`default_nettype none

// Request channel: one queue operation per item
interface cqe_in_if
    import cqe_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    cmd_t                           cmd;
    logic signed [VALUE_WIDTH-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel: status and queue ends after each operation
interface cqe_out_if
    import cqe_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic signed [VALUE_WIDTH-1:0]  front_value;
    logic signed [VALUE_WIDTH-1:0]  rear_value;
    logic                           empty_res;
    logic                           full_res;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input empty_res, input full_res, output ready);
endinterface

`default_nettype wire

FILE: src/circular_queue_engine.sv
// An enqueue or a refused operation shows its result in the cycle after acceptance;
// a dequeue that leaves elements behind passes through S_FETCH first (one read of the slot memory).
// One item at a time; a new item is taken only once the previous result is taken.
// Reset: asynchronous, active low; the queue is empty and capacity is min(1024, MAX_DEPTH).
// The slot memory is not cleared; a slot's data is only used after being written.
`default_nettype none

module circular_queue_engine
    import cqe_pkg::*;
#(
    parameter int MAX_DEPTH   = 1024,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CAP_WIDTH-1:0] cfg_wdata,
    cqe_in_if.sink                    in_ch,
    cqe_out_if.source                 out_ch
);

    localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW      = $clog2(MAX_DEPTH + 1);
    localparam int CAP_RST = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_FETCH,
        S_HOLD
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           head_reg;
    logic [AW-1:0]           tail_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           cap_reg;
    logic [VALUE_WIDTH-1:0]  front_reg;
    logic [VALUE_WIDTH-1:0]  rear_reg;
    logic                    ok_reg;
    logic                    empty_reg;
    logic                    full_reg;

    logic [VALUE_WIDTH-1:0]  slot_mem [MAX_DEPTH];
    logic [VALUE_WIDTH-1:0]  rd_data_reg;

    logic                    accept;
    logic                    do_enq;
    logic                    do_deq;
    logic [CW:0]             head_inc;
    logic [CW:0]             tail_inc;
    logic [AW-1:0]           head_step;
    logic [AW-1:0]           tail_step;
    logic [CW-1:0]           cap_limited;
    logic [CW-1:0]           count_inc;
    logic [CW-1:0]           count_dec;

    // Handshake
    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_HOLD);

    // Decide the operation against the current fill level
    assign do_enq = accept && (in_ch.cmd == CMD_ENQ) && (count_reg < cap_reg);
    assign do_deq = accept && (in_ch.cmd == CMD_DEQ) && (count_reg != '0);

    // Advance pointers with a wrap at the capacity
    assign head_inc  = (CW+1)'(head_reg) + 1'b1;
    assign tail_inc  = (CW+1)'(tail_reg) + 1'b1;
    assign head_step = (head_inc >= {1'b0, cap_reg}) ? '0 : head_inc[AW-1:0];
    assign tail_step = (tail_inc >= {1'b0, cap_reg}) ? '0 : tail_inc[AW-1:0];
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // Limit a written capacity to 1..MAX_DEPTH
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_limited = CW'(1);
        else if (32'(cfg_wdata) > 32'(MAX_DEPTH))
            cap_limited = CW'(MAX_DEPTH);
        else
            cap_limited = CW'(cfg_wdata);
    end

    // Slot memory: write on enqueue, read the new head on dequeue
    always_ff @(posedge clk)
    begin
        if (do_enq)
            slot_mem[tail_reg] <= in_ch.value;
        if (do_deq)
            rd_data_reg <= slot_mem[head_step];
    end

    // Cached queue ends; payload only
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            rear_reg <= in_ch.value;
            if (count_reg == '0)
                front_reg <= in_ch.value;
        end
        if (state_reg == S_FETCH)
            front_reg <= rd_data_reg;
    end

    // Control state, pointers and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CW'(CAP_RST);
            ok_reg    <= 1'b0;
            empty_reg <= 1'b1;
            full_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_limited;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ok_reg    <= do_enq || do_deq;
                        state_reg <= S_HOLD;
                        empty_reg <= (count_reg == '0);
                        full_reg  <= (count_reg == cap_reg);
                        if (do_enq)
                        begin
                            tail_reg  <= tail_step;
                            count_reg <= count_inc;
                            empty_reg <= 1'b0;
                            full_reg  <= (count_inc == cap_reg);
                        end
                        else if (do_deq)
                        begin
                            count_reg <= count_dec;
                            full_reg  <= (count_dec == cap_reg);
                            if (count_dec == '0)
                            begin
                                head_reg  <= '0;
                                tail_reg  <= '0;
                                empty_reg <= 1'b1;
                            end
                            else
                            begin
                                head_reg  <= head_step;
                                empty_reg <= 1'b0;
                                state_reg <= S_FETCH;
                            end
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Drive the result; an empty queue shows all ones at both ends
    assign out_ch.ok          = ok_reg;
    assign out_ch.empty_res   = empty_reg;
    assign out_ch.full_res    = full_reg;
    assign out_ch.front_value = empty_reg ? '1 : front_reg;
    assign out_ch.rear_value  = empty_reg ? '1 : rear_reg;

    // Fill level never passes the capacity
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("element count above capacity");

    // An empty queue has both pointers at slot 0
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("pointers not reset on empty queue");

    // Pointers stay inside the configured capacity
    a_ptrs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < (AW+1)'(cap_reg)) && ({1'b0, tail_reg} < (AW+1)'(cap_reg)))
        else $error("pointer outside capacity");

    // A memory fetch always completes into a presented result
    a_fetch_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH && !cfg_we) |=> (state_reg == S_HOLD))
        else $error("fetch did not lead to result");

endmodule

`default_nettype wire

FILE: tb/cqe_queue_checker.sv
`timescale 1ns / 1ps

module cqe_queue_checker
    import cqe_pkg::*;
#(
    parameter int MAX_DEPTH   = 1024,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CAP_WIDTH-1:0] cfg_wdata,
    cqe_in_if                    in_ch,
    cqe_out_if                   out_ch,
    output int                   mismatch_count,
    output int                   awaiting_count,
    output int                   results_seen,
    output int                   refused_seen,
    output int                   full_seen
);

    typedef struct packed {
        logic                   ok;
        logic [VALUE_WIDTH-1:0] front;
        logic [VALUE_WIDTH-1:0] rear;
        logic                   empty;
        logic                   full;
    } queue_status_t;

    // Shadow copy of the ring buffer
    logic [VALUE_WIDTH-1:0] slot_mem [MAX_DEPTH];
    int unsigned            cap_slots;
    int unsigned            head_pos;
    int unsigned            tail_pos;
    int unsigned            fill_count;

    queue_status_t status_q [$];
    int            err_total = 0;
    int            awaiting  = 0;
    int            seen_total = 0;
    int            refused_total = 0;
    int            full_total = 0;

    assign mismatch_count = err_total;
    assign awaiting_count = awaiting;
    assign results_seen   = seen_total;
    assign refused_seen   = refused_total;
    assign full_seen      = full_total;

    function automatic int unsigned clamp_capacity(input int unsigned req);
        if (req == 0)
            return 1;
        if (req > MAX_DEPTH)
            return MAX_DEPTH;
        return req;
    endfunction

    function automatic int unsigned next_pos(input int unsigned pos);
        return (pos + 1 >= cap_slots) ? 0 : pos + 1;
    endfunction

    // Apply one queue operation to the shadow state and return the status after it
    function automatic queue_status_t apply_queue_op(input cmd_t op,
                                                     input logic [VALUE_WIDTH-1:0] val);
        queue_status_t st;
        int unsigned   rear_pos;
        st.ok = 1'b0;
        if (op == CMD_ENQ) begin
            if (fill_count < cap_slots) begin
                slot_mem[tail_pos] = val;
                tail_pos = next_pos(tail_pos);
                fill_count++;
                st.ok = 1'b1;
            end
        end
        else if (fill_count != 0) begin
            fill_count--;
            // restart both pointers at slot 0 once the queue drains
            if (fill_count == 0) begin
                head_pos = 0;
                tail_pos = 0;
            end
            else begin
                head_pos = next_pos(head_pos);
            end
            st.ok = 1'b1;
        end
        st.front = '1;
        st.rear  = '1;
        if (fill_count != 0) begin
            rear_pos = (tail_pos == 0) ? cap_slots - 1 : tail_pos - 1;
            st.front = slot_mem[head_pos];
            st.rear  = slot_mem[rear_pos];
        end
        st.empty = (fill_count == 0);
        st.full  = (fill_count == cap_slots);
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        err_total++;
        if (err_total <= 40)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input int idx,
                               input logic [VALUE_WIDTH-1:0] got,
                               input logic [VALUE_WIDTH-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      idx, field, got, want));
    endtask

    // Track config, compare results, then queue the prediction for a new item
    always @(posedge clk or negedge rst_n) begin
        queue_status_t want;
        if (!rst_n) begin
            cap_slots  = clamp_capacity(CAP_RESET);
            head_pos   = 0;
            tail_pos   = 0;
            fill_count = 0;
            status_q.delete();
            awaiting <= 0;
        end
        else begin
            if (cfg_we) begin
                cap_slots  = clamp_capacity(32'(cfg_wdata));
                head_pos   = 0;
                tail_pos   = 0;
                fill_count = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              seen_total));
                end
                else begin
                    want = status_q.pop_front();
                    check_field("ok", seen_total, VALUE_WIDTH'(out_ch.ok),
                                VALUE_WIDTH'(want.ok));
                    check_field("front_value", seen_total, out_ch.front_value, want.front);
                    check_field("rear_value", seen_total, out_ch.rear_value, want.rear);
                    check_field("empty_res", seen_total, VALUE_WIDTH'(out_ch.empty_res),
                                VALUE_WIDTH'(want.empty));
                    check_field("full_res", seen_total, VALUE_WIDTH'(out_ch.full_res),
                                VALUE_WIDTH'(want.full));
                    if (!want.ok)
                        refused_total++;
                    if (want.full)
                        full_total++;
                end
                seen_total++;
            end
            if (in_ch.valid && in_ch.ready)
                status_q.push_back(apply_queue_op(in_ch.cmd, in_ch.value));
            awaiting <= status_q.size();
        end
    end

endmodule

FILE: tb/tb_circular_queue_engine.sv
`timescale 1ns / 1ps

module tb_circular_queue_engine;
    import cqe_pkg::*;

    localparam int VW          = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_ITEMS  = 700;

    typedef enum int
    {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_HOLD
    } drain_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CAP_WIDTH-1:0] cfg_wdata;

    cqe_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
    cqe_out_if #(.VALUE_WIDTH(VW)) out_ch ();

    int mismatch_count;
    int awaiting_count;
    int results_seen;
    int refused_seen;
    int full_seen;

    int burst_left = 0;
    int cap_writes = 0;
    int idle_cycles = 0;

    circular_queue_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    cqe_queue_checker #(.VALUE_WIDTH(VW)) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .awaiting_count (awaiting_count),
        .results_seen   (results_seen),
        .refused_seen   (refused_seen),
        .full_seen      (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result side on a pattern that is chosen anew at random after each run
    drain_mode_t drain_mode = DRAIN_FREE;
    int          drain_left = 0;

    always @(posedge clk)
    begin
        if (drain_left == 0) begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            drain_left = (drain_mode == DRAIN_HOLD) ? $urandom_range(1, 20)
                                                    : $urandom_range(5, 60);
        end
        drain_left--;
        case (drain_mode)
            DRAIN_FREE:   out_ch.ready <= 1'b1;
            DRAIN_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
            default:      out_ch.ready <= 1'b0;
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CAP_WIDTH-1:0] pick_capacity();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return CAP_WIDTH'($urandom_range(1025, 2047));
            3:       return CAP_WIDTH'(1024);
            4:       return CAP_WIDTH'($urandom_range(17, 200));
            5:       return CAP_WIDTH'(1);
            default: return CAP_WIDTH'($urandom_range(2, 16));
        endcase
    endfunction

    // Drive one item, idling between bursts, and hold until it is taken
    task automatic send_op(input cmd_t op, input logic [VW-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= op;
        in_ch.value <= val;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaiting_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] req);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= req;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    initial
    begin
        int rand_done;
        int phase_len;
        int enq_pct;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_ENQ;
        in_ch.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: refused dequeue, value extremes, drain to empty
        send_op(CMD_DEQ, '1);
        send_op(CMD_ENQ, 32'h8000_0000);
        send_op(CMD_ENQ, 32'h7fff_ffff);
        send_op(CMD_ENQ, '1);
        send_op(CMD_ENQ, '0);
        repeat (4) send_op(CMD_DEQ, $urandom());
        send_op(CMD_DEQ, '0);
        send_op(CMD_ENQ, 32'h0000_0005);

        // Zero capacity acts as one slot; the write also clears the queue
        write_capacity('0);
        send_op(CMD_DEQ, $urandom());
        send_op(CMD_ENQ, 32'h1234_5678);
        send_op(CMD_ENQ, 32'hdead_beef);
        send_op(CMD_DEQ, '0);

        // Two slots: fill, refuse, wrap the tail, drain
        write_capacity(CAP_WIDTH'(2));
        send_op(CMD_ENQ, 32'h0000_00a1);
        send_op(CMD_ENQ, 32'h0000_00b2);
        send_op(CMD_ENQ, 32'h0000_00c3);
        send_op(CMD_DEQ, '0);
        send_op(CMD_ENQ, 32'h0000_00d4);
        send_op(CMD_DEQ, '0);
        send_op(CMD_DEQ, '0);
        send_op(CMD_DEQ, '0);

        write_capacity(CAP_WIDTH'(1024));
        send_op(CMD_ENQ, pick_value());
        send_op(CMD_DEQ, '0);

        // Oversized capacity clamps to full depth: fill partway, mix, drain
        write_capacity(CAP_WIDTH'(1025));
        repeat (40) send_op(CMD_ENQ, pick_value());
        repeat (3) send_op(CMD_DEQ, $urandom());
        repeat (3) send_op(CMD_ENQ, pick_value());
        repeat (40) send_op(CMD_DEQ, $urandom());

        // Random phases over many capacities, each with its own enqueue bias
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            write_capacity(pick_capacity());
            phase_len = $urandom_range(30, 90);
            enq_pct   = $urandom_range(20, 80);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_op(CMD_ENQ, pick_value());
                else
                    send_op(CMD_DEQ, $urandom());
                rand_done++;
            end
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Checked %0d results over %0d capacity writes", results_seen, cap_writes);
        $display("  %0d operations refused, %0d results with the queue full",
                 refused_seen, full_seen);
        if (mismatch_count == 0 && awaiting_count == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, awaiting_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
